[hdl/abst_pkg.sv]
// Package for the array binary search tree: sizes, command and status codes.
// No dependencies.
package abst_pkg;
    localparam int unsigned SLOTS_DEF    = 256;
    localparam int unsigned KEY_BITS_DEF = 32;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_MISSING = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_PRESENT = 2'd3;

    // Which store a datapath access addresses.
    localparam logic [1:0] SEL_CUR    = 2'd0;
    localparam logic [1:0] SEL_SUCC   = 2'd1;
    localparam logic [1:0] SEL_PARENT = 2'd2;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       clear;      // empty the tree
        logic       load;       // latch request, start at root
        logic       rd;         // read node at r_cur
        logic       step;       // compare and descend using read data
        logic       alloc;      // take a slot
        logic       write_new;  // write the new node, link it under parent
        logic       succ_init;  // successor walk starts at right child
        logic       succ_rd;    // read node at successor pointer
        logic       succ_step;  // descend left
        logic       copy_key;   // copy successor key into found node
        logic       splice_s;   // splice out successor
        logic       splice_c;   // splice out found node
        logic       fl_rd;      // read the free stack top
        logic       finish;     // produce the response
        logic [1:0] st;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic       full;       // node count >= capacity
        logic       at_end;     // current pointer is no node or step bound
        logic       hit;        // current node key equals request key
        logic       two_kids;   // found node has both children
        logic       succ_end;   // successor has no left child
        logic       no_slot;    // no free slot
        logic       use_stack;  // slot will come from the free stack
        logic [1:0] cmd;
    } t_sts;
endpackage

[hdl/abst_if.sv]
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
interface abst_if #(parameter int unsigned W = 34);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/abst_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module abst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/abst_datapath.sv]
// Datapath: node stores, free stack, walk pointers and counters.
// Depends on abst_pkg and abst_ram.
module abst_datapath #(
    parameter int unsigned SLOTS    = abst_pkg::SLOTS_DEF,
    parameter int unsigned KEY_BITS = abst_pkg::KEY_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  abst_pkg::t_cmd         i_cmd,
    output abst_pkg::t_sts         o_sts,
    input  logic                   i_cfg_we,
    input  logic [8:0]             i_cfg_data,
    input  logic [1:0]             i_req_cmd,
    input  logic [KEY_BITS-1:0]    i_req_key,
    output logic [1:0]             o_status,
    output logic [7:0]             o_slot,
    output logic [8:0]             o_node_count
);
    import abst_pkg::*;

    localparam int unsigned AW = $clog2(SLOTS);
    localparam int unsigned LW = AW + 1;            // link incl. none marker
    localparam logic [LW-1:0] NONE = LW'(SLOTS);

    logic [LW-1:0]       r_cap, r_fresh, r_depth, r_count, r_root;
    logic [LW-1:0]       r_cur, r_parent, r_succ, r_sp, r_new, r_steps;
    logic                r_went_right, r_sp_right;
    logic [1:0]          r_cmd;
    logic [KEY_BITS-1:0] r_key;
    logic [1:0]          r_status;
    logic [7:0]          r_slot;

    logic [KEY_BITS-1:0] key_rd, key_wd;
    logic [LW-1:0]       left_rd, right_rd, lk_wd, rk_wd, fl_rd;
    logic                key_we, left_we, right_we, fl_we;
    logic [AW-1:0]       rd_addr, key_wa, left_wa, right_wa, fl_wa, fl_ra;

    // Deferred parent link for a new leaf (parent store write after leaf write).
    logic          r_link_pend;
    logic [LW-1:0] r_pl_parent, r_pl_child;
    logic          r_pl_right;
    logic          pl_we_l, pl_we_r;

    logic [LW-1:0] cap_in;
    always_comb begin
        cap_in = i_cfg_data[LW-1:0];
        if (i_cfg_data == 9'd0) cap_in = LW'(1);
        else if ({1'b0, i_cfg_data} > 10'(SLOTS)) cap_in = NONE;
    end

    // Read address: walk pointer or successor pointer.
    assign rd_addr = (i_cmd.succ_rd || i_cmd.succ_step || i_cmd.succ_init)
                     ? r_succ[AW-1:0] : r_cur[AW-1:0];
    assign fl_ra   = AW'(r_depth - LW'(1));

    logic [KEY_BITS-1:0] ok_here, ok_want;
    assign ok_here = key_rd ^ {1'b1, {(KEY_BITS-1){1'b0}}};
    assign ok_want = r_key  ^ {1'b1, {(KEY_BITS-1){1'b0}}};

    // Splice helper: link to place under a parent.
    logic          sp_en, sp_right;
    logic [LW-1:0] sp_parent, sp_child;
    always_comb begin
        sp_en = 1'b0; sp_right = 1'b0; sp_parent = NONE; sp_child = NONE;
        if (i_cmd.write_new) begin
            sp_en = 1'b1; sp_parent = r_parent; sp_right = r_went_right;
            sp_child = r_new;
        end else if (i_cmd.splice_s) begin
            sp_en = 1'b1; sp_parent = r_sp; sp_right = r_sp_right;
            sp_child = right_rd;
        end else if (i_cmd.splice_c) begin
            sp_en = 1'b1; sp_parent = r_parent; sp_right = r_went_right;
            sp_child = (left_rd < NONE) ? left_rd : right_rd;
        end
    end

    // The deferred parent link uses the cycle after write_new, where the
    // controller issues no other store write.
    assign pl_we_l = r_link_pend && r_pl_parent < NONE && !r_pl_right;
    assign pl_we_r = r_link_pend && r_pl_parent < NONE && r_pl_right;

    always_comb begin
        key_we = 1'b0; key_wa = r_new[AW-1:0]; key_wd = r_key;
        left_we = 1'b0; left_wa = r_new[AW-1:0]; lk_wd = NONE;
        right_we = 1'b0; right_wa = r_new[AW-1:0]; rk_wd = NONE;
        if (i_cmd.write_new) begin
            key_we = 1'b1; left_we = 1'b1; right_we = 1'b1;
        end
        if (i_cmd.copy_key) begin
            key_we = 1'b1; key_wa = r_cur[AW-1:0]; key_wd = key_rd;
        end
        // A splice overrides only the parent's link; write_new writes a
        // fresh leaf, so the parent link goes in the following cycle.
        if (sp_en && !i_cmd.write_new && sp_parent < NONE) begin
            if (sp_right) begin
                right_we = 1'b1; right_wa = sp_parent[AW-1:0]; rk_wd = sp_child;
            end else begin
                left_we = 1'b1; left_wa = sp_parent[AW-1:0]; lk_wd = sp_child;
            end
        end
        if (pl_we_l) begin
            left_we = 1'b1; left_wa = r_pl_parent[AW-1:0]; lk_wd = r_pl_child;
        end
        if (pl_we_r) begin
            right_we = 1'b1; right_wa = r_pl_parent[AW-1:0]; rk_wd = r_pl_child;
        end
        fl_we = (i_cmd.splice_s || i_cmd.splice_c) && (r_depth < NONE);
        fl_wa = r_depth[AW-1:0];
    end

    abst_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key (
        .i_clk, .i_we(key_we), .i_waddr(key_wa), .i_wdata(key_wd),
        .i_raddr(rd_addr), .o_rdata(key_rd));
    abst_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_left (
        .i_clk, .i_we(left_we), .i_waddr(left_wa), .i_wdata(lk_wd),
        .i_raddr(rd_addr), .o_rdata(left_rd));
    abst_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_right (
        .i_clk, .i_we(right_we), .i_waddr(right_wa), .i_wdata(rk_wd),
        .i_raddr(rd_addr), .o_rdata(right_rd));
    abst_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_free (
        .i_clk, .i_we(fl_we), .i_waddr(fl_wa),
        .i_wdata(i_cmd.splice_s ? r_succ : r_cur),
        .i_raddr(fl_ra), .o_rdata(fl_rd));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= NONE; r_fresh <= NONE; r_depth <= '0; r_count <= '0;
            r_root <= NONE; r_link_pend <= 1'b0;
        end else if (i_cfg_we || i_cmd.clear) begin
            if (i_cfg_we) begin
                r_cap <= cap_in; r_fresh <= cap_in;
            end else begin
                r_fresh <= r_cap;
            end
            r_depth <= '0; r_count <= '0; r_root <= NONE; r_link_pend <= 1'b0;
        end else begin
            r_link_pend <= i_cmd.write_new;
            if (i_cmd.alloc) begin
                if (r_depth != '0) begin
                    r_depth <= r_depth - LW'(1);
                end else if (r_fresh != '0) begin
                    r_fresh <= r_fresh - LW'(1);
                end
            end
            if (i_cmd.write_new) begin
                r_count <= r_count + LW'(1);
            end
            if (i_cmd.splice_s || i_cmd.splice_c) begin
                if (r_depth < NONE) r_depth <= r_depth + LW'(1);
                if (r_count != '0) r_count <= r_count - LW'(1);
            end
            if (sp_en && sp_parent == NONE) r_root <= sp_child;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_new) begin
            r_pl_parent <= r_parent; r_pl_child <= r_new; r_pl_right <= r_went_right;
        end
    end

    // Payload registers for the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_req_cmd; r_key <= i_req_key; r_cur <= r_root;
            r_parent <= NONE; r_went_right <= 1'b0; r_steps <= '0;
        end
        if (i_cmd.step) begin
            r_parent <= r_cur;
            r_went_right <= ok_here < ok_want;
            r_cur <= (ok_here < ok_want) ? right_rd : left_rd;
            r_steps <= r_steps + LW'(1);
        end
        if (i_cmd.alloc) begin
            r_new <= (r_depth != '0) ? fl_rd : r_fresh - LW'(1);
        end
        if (i_cmd.succ_init) begin
            r_succ <= right_rd; r_sp <= r_cur; r_sp_right <= 1'b1; r_steps <= '0;
        end
        if (i_cmd.succ_step) begin
            r_sp <= r_succ; r_sp_right <= 1'b0; r_succ <= left_rd;
            r_steps <= r_steps + LW'(1);
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.st;
            unique case (i_cmd.st)
                ST_DONE:    r_slot <= (r_cmd == CMD_INSERT) ? r_new[7:0]
                                     : (r_cmd == CMD_FIND) ? r_cur[7:0] : 8'd0;
                ST_PRESENT: r_slot <= r_cur[7:0];
                default:    r_slot <= 8'd0;
            endcase
        end
    end

    assign o_sts.full      = r_count >= r_cap;
    assign o_sts.at_end    = !(r_cur < NONE) || (r_steps > NONE);
    assign o_sts.hit       = ok_here == ok_want;
    assign o_sts.two_kids  = (left_rd < NONE) && (right_rd < NONE);
    assign o_sts.succ_end  = !(left_rd < NONE) || (r_steps >= NONE);
    assign o_sts.no_slot   = (r_depth == '0) && (r_fresh == '0);
    assign o_sts.use_stack = r_depth != '0;
    assign o_sts.cmd       = r_cmd;

    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_node_count = 9'(r_count);
endmodule

[hdl/abst_ctrl.sv]
// Controller state machine sequencing walk, insert and remove.
// Depends on abst_pkg.
module abst_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  abst_pkg::t_sts i_sts,
    output abst_pkg::t_cmd o_cmd
);
    import abst_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_CMP   = 4'd2;
    localparam logic [3:0] S_ALLOC = 4'd3;
    localparam logic [3:0] S_WNEW  = 4'd4;
    localparam logic [3:0] S_LINK  = 4'd5;
    localparam logic [3:0] S_SRD   = 4'd6;
    localparam logic [3:0] S_SCMP  = 4'd7;
    localparam logic [3:0] S_RESP  = 4'd8;
    localparam logic [3:0] S_FLRD  = 4'd9;
    localparam logic [3:0] S_SINIT = 4'd10;

    logic [3:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic [1:0] r_st, n_st;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state; n_out_valid = r_out_valid; n_st = r_st;
        o_cmd = '0;
        o_cmd.st = r_st;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                if (i_sts.cmd == CMD_INSERT && i_sts.full) begin
                    n_st = ST_FULL; n_state = S_RESP;
                end else if (i_sts.cmd != CMD_INSERT && i_sts.cmd != CMD_FIND
                             && i_sts.cmd != CMD_REMOVE) begin
                    n_st = ST_MISSING; n_state = S_RESP;
                end else if (i_sts.at_end) begin
                    if (i_sts.cmd == CMD_INSERT) begin
                        n_state = S_FLRD;
                    end else begin
                        n_st = ST_MISSING; n_state = S_RESP;
                    end
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_sts.hit) begin
                    unique case (i_sts.cmd)
                        CMD_INSERT: begin n_st = ST_PRESENT; n_state = S_RESP; end
                        CMD_FIND:   begin n_st = ST_DONE; n_state = S_RESP; end
                        default: begin
                            n_st = ST_DONE;
                            if (i_sts.two_kids) begin
                                o_cmd.succ_init = 1'b1; n_state = S_SINIT;
                            end else begin
                                o_cmd.splice_c = 1'b1; n_state = S_RESP;
                            end
                        end
                    endcase
                end else begin
                    o_cmd.step = 1'b1; n_state = S_RD;
                end
            end
            S_FLRD: begin
                if (i_sts.no_slot) begin
                    n_st = ST_FULL; n_state = S_RESP;
                end else begin
                    n_state = S_ALLOC;
                end
            end
            S_ALLOC: begin o_cmd.alloc = 1'b1; n_state = S_WNEW; end
            S_WNEW:  begin o_cmd.write_new = 1'b1; n_st = ST_DONE; n_state = S_LINK; end
            S_LINK:  n_state = S_RESP;
            S_SINIT: n_state = S_SRD;
            S_SRD:   begin o_cmd.succ_rd = 1'b1; n_state = S_SCMP; end
            S_SCMP: begin
                if (i_sts.succ_end) begin
                    o_cmd.copy_key = 1'b1; o_cmd.splice_s = 1'b1; n_state = S_RESP;
                end else begin
                    o_cmd.succ_step = 1'b1; n_state = S_SRD;
                end
            end
            S_RESP: begin
                o_cmd.finish = 1'b1; o_cmd.st = r_st;
                n_out_valid = 1'b1; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= S_IDLE; r_out_valid <= 1'b0; r_st <= ST_DONE;
        end else begin
            r_state <= n_state; r_out_valid <= n_out_valid; r_st <= n_st;
        end
    end
endmodule

[hdl/array_binary_search_tree.sv]
// Top level of the array binary search tree.
// Depends on abst_pkg, abst_if, abst_ctrl and abst_datapath.
//
//  channel | dir | payload                          | handshake
//  req     | in  | cmd[1:0], key[KEY_BITS-1:0]      | valid/ready
//  rsp     | out | status[1:0], slot[7:0], cnt[8:0] | valid/ready
//  cfg     | in  | capacity[8:0]                    | write enable
//
// A request is taken when idle; each tree node is then read, then compared;
// a two-child remove adds a read and a check per successor-walk node, and a
// new insert adds the slot check, allocation, leaf write and parent link.
// Read and compare are separate steps: each node store has one read port.
// Reset (synchronous, active low) empties the tree; capacity becomes SLOTS.
// A finished response waits in its register; the next request is taken
// as soon as that response is taken or in the same cycle.
module array_binary_search_tree #(
    parameter int unsigned SLOTS    = abst_pkg::SLOTS_DEF,
    parameter int unsigned KEY_BITS = abst_pkg::KEY_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [8:0] i_cfg_data,
    abst_if.sink       i_req,
    abst_if.source     o_rsp
);
    import abst_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic [1:0] status;
    logic [7:0] slot;
    logic [8:0] count;

    abst_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_we,
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_sts(sts), .o_cmd(cmd));

    abst_datapath #(.SLOTS(SLOTS), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_sts(sts),
        .i_cfg_we, .i_cfg_data,
        .i_req_cmd(i_req.data[1:0]), .i_req_key(i_req.data[KEY_BITS+1:2]),
        .o_status(status), .o_slot(slot), .o_node_count(count));

    // Response payload: {node_count, slot, status}.
    assign o_rsp.data = {count, slot, status};
endmodule

[dv/array_binary_search_tree_tb.sv]
// Testbench for the array binary search tree: directed and random inserts, finds
// and removes checked against a behavioral tree predictor. Depends on abst_pkg,
// abst_if and array_binary_search_tree.
module array_binary_search_tree_tb;
    import abst_pkg::*;

    localparam int unsigned SLOTS  = 256;
    localparam int unsigned NONE   = SLOTS;
    localparam logic [1:0]  CMD_UNUSED = 2'd3;
    localparam int unsigned LIMIT  = 3000000;

    typedef struct packed {
        logic [8:0] count;
        logic [7:0] slot;
        logic [1:0] status;
    } t_answer;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [8:0] i_cfg_data;

    abst_if #(.W(34)) req_ch ();
    abst_if #(.W(19)) rsp_ch ();

    array_binary_search_tree u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch.sink),
        .o_rsp      (rsp_ch.source)
    );

    // The predictor keeps its own copy of the tree.
    logic signed [31:0] tree_key [SLOTS];
    int unsigned tree_left [SLOTS];
    int unsigned tree_right [SLOTS];
    int unsigned free_stack [SLOTS];
    int unsigned tree_root;
    int unsigned tree_count;
    int unsigned free_depth;
    int unsigned fresh_next;
    int unsigned tree_capacity;

    t_answer answers_due [$];
    logic signed [31:0] live_keys [$];
    int unsigned errors;
    int unsigned cycles;
    int unsigned answers_seen;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout at %0t with %0d answers pending", $time, answers_due.size());
            $display("array_binary_search_tree_tb: done, errors");
            $finish;
        end
    end

    function automatic void tree_empty(input int unsigned cap);
        tree_capacity = cap;
        tree_root = NONE;
        tree_count = 0;
        free_depth = 0;
        fresh_next = cap;
        live_keys.delete();
    endfunction

    function automatic void link_child(input int unsigned parent, input bit to_right,
                                       input int unsigned child);
        if (parent >= SLOTS) begin
            tree_root = child;
        end else if (to_right) begin
            tree_right[parent] = child;
        end else begin
            tree_left[parent] = child;
        end
    endfunction

    function automatic void release_slot(input int unsigned s);
        if (free_depth < SLOTS) begin
            free_stack[free_depth] = s;
            free_depth++;
        end
    endfunction

    // Applies one request to the predicted tree and returns the answer.
    function automatic t_answer tree_apply(input logic [1:0] cmd, input logic signed [31:0] key);
        t_answer a;
        int unsigned cur, parent, s, sp, steps;
        bit went_right, found, sp_right;
        a = '{status: ST_MISSING, slot: 8'd0, count: 9'd0};
        cur = tree_root;
        parent = NONE;
        went_right = 0;
        found = 0;
        steps = 0;
        if (cmd == CMD_INSERT && tree_count >= tree_capacity) begin
            a.status = ST_FULL;
        end else if (cmd != CMD_UNUSED) begin
            while (cur < SLOTS && steps <= SLOTS) begin
                if (tree_key[cur] == key) begin
                    found = 1;
                    break;
                end
                parent = cur;
                went_right = tree_key[cur] < key;
                cur = went_right ? tree_right[cur] : tree_left[cur];
                steps++;
            end
            if (cmd == CMD_INSERT) begin
                if (found) begin
                    a.status = ST_PRESENT;
                    a.slot = cur[7:0];
                end else begin
                    if (free_depth > 0) begin
                        free_depth--;
                        s = free_stack[free_depth];
                    end else if (fresh_next > 0) begin
                        fresh_next--;
                        s = fresh_next;
                    end else begin
                        s = NONE;
                    end
                    if (s >= SLOTS) begin
                        a.status = ST_FULL;
                    end else begin
                        tree_key[s] = key;
                        tree_left[s] = NONE;
                        tree_right[s] = NONE;
                        link_child(parent, went_right, s);
                        tree_count++;
                        live_keys.push_back(key);
                        a.status = ST_DONE;
                        a.slot = s[7:0];
                    end
                end
            end else if (cmd == CMD_FIND) begin
                if (found) begin
                    a.status = ST_DONE;
                    a.slot = cur[7:0];
                end
            end else if (found) begin
                if (tree_left[cur] < SLOTS && tree_right[cur] < SLOTS) begin
                    // Two children: the in-order successor's key moves up and
                    // the successor's slot is spliced out instead.
                    sp = cur;
                    s = tree_right[cur];
                    sp_right = 1;
                    steps = 0;
                    while (tree_left[s] < SLOTS && steps < SLOTS) begin
                        sp = s;
                        sp_right = 0;
                        s = tree_left[s];
                        steps++;
                    end
                    tree_key[cur] = tree_key[s];
                    link_child(sp, sp_right, tree_right[s]);
                    release_slot(s);
                end else begin
                    link_child(parent, went_right,
                               tree_left[cur] < SLOTS ? tree_left[cur] : tree_right[cur]);
                    release_slot(cur);
                end
                if (tree_count > 0) tree_count--;
                foreach (live_keys[i]) begin
                    if (live_keys[i] == key) begin
                        live_keys.delete(i);
                        break;
                    end
                end
                a.status = ST_DONE;
            end
        end
        a.count = tree_count[8:0];
        return a;
    endfunction

    // Sends one request; the expectation is queued at the accepting edge.
    // Valid stays high after acceptance until the next idle cycle or drain.
    task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] key);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= {key, cmd};
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        answers_due.push_back(tree_apply(cmd, key));
    endtask

    // Receiver: random stalls, and each accepted answer checked against the oldest one due.
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = rsp_ch.data;
            answers_seen <= answers_seen + 1;
            if (answers_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected answer %p", $time, got);
            end else begin
                want = answers_due.pop_front();
                if (got.status !== want.status || got.slot !== want.slot
                        || got.count !== want.count) begin
                    errors++;
                    $display("%0t: expected %p, actual %p", $time, want, got);
                end
            end
        end
        rsp_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [8:0] cap);
        int unsigned eff;
        wait_drained();
        eff = (cap == 0) ? 1 : (cap > SLOTS ? SLOTS : cap);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= cap;
        @(posedge i_clk);
        tree_empty(eff);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_key();
        if (live_keys.size() != 0 && $urandom_range(99) < 55) begin
            return live_keys[$urandom_range(live_keys.size() - 1)];
        end
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(40)) - 20;
            default: return $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    // Field extremes, every command, duplicates, misses, unused command and
    // removal of a node with two children (its successor deep on the left).
    task automatic test_directed();
        send_request(CMD_FIND, 32'sd5);
        send_request(CMD_REMOVE, 32'sd5);
        send_request(CMD_INSERT, 32'sd0);
        send_request(CMD_INSERT, 32'h7fffffff);
        send_request(CMD_INSERT, 32'h80000000);
        send_request(CMD_INSERT, -32'sd1);
        send_request(CMD_INSERT, 32'sd50);
        send_request(CMD_INSERT, 32'sd20);
        send_request(CMD_INSERT, 32'sd30);
        send_request(CMD_INSERT, 32'sd50);
        send_request(CMD_FIND, 32'h80000000);
        send_request(CMD_FIND, 32'sd30);
        send_request(CMD_UNUSED, 32'sd30);
        send_request(CMD_REMOVE, 32'sd0);
        send_request(CMD_REMOVE, 32'h80000000);
        send_request(CMD_REMOVE, 32'sd0);
        send_request(CMD_INSERT, 32'sd7);
        send_request(CMD_FIND, 32'sd7);
        send_request(CMD_REMOVE, 32'sd7);
        send_request(CMD_REMOVE, 32'h7fffffff);
    endtask

    // Tiny capacities, including out-of-range writes that clamp, reach the full case.
    task automatic test_capacity_limits();
        set_capacity(9'd0);
        send_request(CMD_INSERT, 32'sd3);
        send_request(CMD_INSERT, 32'sd4);
        send_request(CMD_FIND, 32'sd3);
        send_request(CMD_REMOVE, 32'sd3);
        send_request(CMD_INSERT, 32'sd4);
        set_capacity(9'd3);
        for (int i = 0; i < 5; i++) send_request(CMD_INSERT, $signed(i * 3 - 4));
        send_request(CMD_REMOVE, -32'sd1);
        send_request(CMD_INSERT, 32'sd9);
        set_capacity(9'h1ff);
    endtask

    task automatic test_random(input int unsigned n);
        int unsigned r;
        logic [1:0] cmd;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            cmd = r < 50 ? CMD_INSERT : (r < 70 ? CMD_FIND : (r < 98 ? CMD_REMOVE : CMD_UNUSED));
            send_request(cmd, pick_key());
        end
    endtask

    // Walk through the idling phases at a few capacities.
    task automatic test_random_phases();
        set_capacity(9'd256);
        send_idle_pct = 0;  stall_pct = 0;  test_random(90);
        send_idle_pct = 66; stall_pct = 0;  test_random(80);
        set_capacity(9'd12);
        send_idle_pct = 0;  stall_pct = 66; test_random(90);
        set_capacity(9'd1);
        send_idle_pct = 28; stall_pct = 28; test_random(20);
        set_capacity(9'd40);
        send_idle_pct = 28; stall_pct = 28; test_random(100);
        send_idle_pct = 0;  stall_pct = 0;  test_random(70);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = 9'd0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b1;
        errors = 0;
        cycles = 0;
        answers_seen = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        tree_empty(SLOTS);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity_limits();
        test_random_phases();
        wait_drained();
        repeat (600) @(posedge i_clk);
        $display("Covered inserts, finds, removes and the unused command over capacities 1..256,");
        $display("with %0d answers checked under sender and receiver idling.", answers_seen);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("array_binary_search_tree_tb: done, clean");
        end else begin
            $display("array_binary_search_tree_tb: done, errors");
        end
        $finish;
    end
endmodule

[array_binary_search_tree.f]
hdl/abst_pkg.sv
hdl/abst_if.sv
hdl/abst_ram.sv
hdl/abst_datapath.sv
hdl/abst_ctrl.sv
hdl/array_binary_search_tree.sv
dv/array_binary_search_tree_tb.sv
